// File: src/joystick_axis_conditioner_top_macros.svh
// ----------------------------------------------------------------------------
// joystick axis conditioner assertion macros
// clocked assertion helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_TOP_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked at every edge outside reset
`define JAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define JAC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define JAC_ASSERT(label, prop, msg)
`define JAC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: src/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// shared types and constants of the joystick axis conditioner
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int OUT_W       = 16;
    localparam int CONFIRM_W   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int MAG_W       = 15;
    localparam int NUM_W       = SQ_W + MAG_W + 1;

    // window length and its position counter
    localparam int WIN_LEN     = 10;
    localparam int WIN_POS_W   = $clog2(WIN_LEN + 1);

    // plausible calibrated center band
    localparam logic [SAMPLE_W-1:0] CENTER_LOW  = 12'd1024;
    localparam logic [SAMPLE_W-1:0] CENTER_HIGH = 12'd3072;

    // full scale in q1.15
    localparam logic [MAG_W-1:0] Q_ONE = 15'h7FFF;

    // one quotient bit per divider step
    localparam int DIV_STEPS   = MAG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CONFIRM_W-1:0] STREAK_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOME_X        = 3'd0,
        CFG_HOME_Y        = 3'd1,
        CFG_DEAD_BAND     = 3'd2,
        CFG_MID_LOW       = 3'd3,
        CFG_MID_HIGH      = 3'd4,
        CFG_MOVE_RANGE    = 3'd5,
        CFG_REST_BAND     = 3'd6,
        CFG_CONFIRM_COUNT = 3'd7
    } t_cfg_idx;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic eval;
        logic sq_d;
        logic sq_c;
        logic num;
        logic div_step;
        logic out_load;
    } t_jac_cmd;

endpackage

// File: src/jac_ctrl.sv
// ----------------------------------------------------------------------------
// jac_ctrl
// sequencer: accept, evaluate, square, divide, hand off to the output register
// ----------------------------------------------------------------------------
`include "joystick_axis_conditioner_top_macros.svh"

module jac_ctrl
    import jac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_jac_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SQD,
        S_SQC,
        S_NUM,
        S_DIV,
        S_FIN
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    t_jac_cmd               cmd;

    always_comb begin
        cmd          = '0;
        cmd.load     = (r_state == S_IDLE) && i_in_valid;
        cmd.eval     = (r_state == S_EVAL);
        cmd.sq_d     = (r_state == S_SQD);
        cmd.sq_c     = (r_state == S_SQC);
        cmd.num      = (r_state == S_NUM);
        cmd.div_step = (r_state == S_DIV);
        cmd.out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (cmd.load) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: n_state = S_SQD;
            S_SQD:  n_state = S_SQC;
            S_SQC:  n_state = S_NUM;
            S_NUM: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (cmd.out_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `JAC_ASSERT(a_no_overwrite, (r_out_valid && !i_out_ready) |-> !cmd.out_load, "result overwritten")
    `JAC_ASSERT(a_load_to_eval, cmd.load |=> (r_state == S_EVAL), "accepted item not evaluated")
    `JAC_ASSERT(a_div_len, (r_state == S_DIV && r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_FIN), "divider length wrong")
    `JAC_ASSERT(a_valid_src, $rose(r_out_valid) |-> $past(cmd.out_load), "result shown without load")

endmodule

// File: src/jac_dp.sv
// ----------------------------------------------------------------------------
// jac_dp
// config registers, window tracking, connect check and per-axis shaping lanes
// ----------------------------------------------------------------------------
module jac_dp
    import jac_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_jac_cmd                    i_cmd,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [SAMPLE_W-1:0]         i_cfg_data,
    input  logic [SAMPLE_W-1:0]         i_x_sample,
    input  logic [SAMPLE_W-1:0]         i_y_sample,
    output logic signed [OUT_W-1:0]     o_x_out,
    output logic signed [OUT_W-1:0]     o_y_out,
    output logic                        o_connected
);

    // configuration
    logic [SAMPLE_W-1:0]  r_center [2];
    logic [SAMPLE_W-1:0]  r_dead_band, r_mid_low, r_mid_high, r_move_range, r_rest_band;
    logic [CONFIRM_W-1:0] r_confirm;

    // window and streak state
    logic [SAMPLE_W-1:0]  r_wmin [2];
    logic [SAMPLE_W-1:0]  r_wmax [2];
    logic [WIN_POS_W-1:0] r_win_pos;
    logic [CONFIRM_W-1:0] r_streak, n_streak;
    logic                 r_conn, n_conn;

    // lanes
    logic [SAMPLE_W-1:0]  r_raw [2];
    logic [SAMPLE_W-1:0]  r_c [2];
    logic [SAMPLE_W-1:0]  r_d [2];
    logic                 r_neg [2];
    logic                 r_zero [2];
    logic                 r_sat [2];
    logic [SQ_W-1:0]      r_dd [2];
    logic [SQ_W-1:0]      r_cc [2];
    logic [SQ_W-1:0]      r_rem [2];
    logic [MAG_W-1:0]     r_lo [2];
    logic [MAG_W-1:0]     r_q [2];

    logic [SAMPLE_W-1:0]  w_in [2];
    logic [SAMPLE_W-1:0]  w_ceff [2];
    logic                 w_neg [2];
    logic [SAMPLE_W-1:0]  w_d [2];
    logic [SAMPLE_W-1:0]  w_mul_op [2];
    logic [SQ_W-1:0]      w_prod [2];
    logic [NUM_W-1:0]     w_num [2];
    logic [SQ_W:0]        w_trial [2];
    logic [SQ_W:0]        w_diff [2];
    logic                 w_ge [2];
    logic [MAG_W-1:0]     w_mag [2];
    logic [OUT_W-1:0]     w_res [2];

    logic                 mid_ok, moved, ctr_ok, rest_ok, pass;

    assign w_in[0] = i_x_sample;
    assign w_in[1] = i_y_sample;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_ceff[l]   = (r_center[l] == '0) ? SAMPLE_W'(1) : r_center[l];
            w_neg[l]    = r_raw[l] < w_ceff[l];
            w_d[l]      = w_neg[l] ? (w_ceff[l] - r_raw[l]) : (r_raw[l] - w_ceff[l]);
            w_mul_op[l] = i_cmd.sq_c ? r_c[l] : r_d[l];
            w_prod[l]   = w_mul_op[l] * w_mul_op[l];
            // 32767*dd + cc/2
            w_num[l]    = {1'b0, r_dd[l], {MAG_W{1'b0}}} - {{(MAG_W+1){1'b0}}, r_dd[l]}
                        + {{(MAG_W+2){1'b0}}, r_cc[l][SQ_W-1:1]};
            w_trial[l]  = {r_rem[l], r_lo[l][MAG_W-1]};
            w_ge[l]     = w_trial[l] >= {1'b0, r_cc[l]};
            w_diff[l]   = w_trial[l] - {1'b0, r_cc[l]};
            w_mag[l]    = r_zero[l] ? '0 : (r_sat[l] ? Q_ONE : r_q[l]);
            w_res[l]    = r_neg[l] ? (OUT_W'(0) - {1'b0, w_mag[l]}) : {1'b0, w_mag[l]};
        end
    end

    // connect check on the updated window
    always_comb begin
        mid_ok = ((r_raw[0] >= r_mid_low) && (r_raw[0] <= r_mid_high))
              || ((r_raw[1] >= r_mid_low) && (r_raw[1] <= r_mid_high));
        moved  = ((r_wmax[0] - r_wmin[0]) > r_move_range)
              || ((r_wmax[1] - r_wmin[1]) > r_move_range);
        ctr_ok = (w_ceff[0] >= CENTER_LOW) && (w_ceff[0] <= CENTER_HIGH)
              && (w_ceff[1] >= CENTER_LOW) && (w_ceff[1] <= CENTER_HIGH);
        rest_ok = (w_d[0] <= r_rest_band) || (w_d[1] <= r_rest_band);
        pass   = mid_ok || moved || (ctr_ok && rest_ok);
        if (pass) begin
            n_streak = '0;
        end else if (r_streak == STREAK_MAX) begin
            n_streak = r_streak;
        end else begin
            n_streak = r_streak + 1'b1;
        end
        n_conn = pass || (n_streak < r_confirm);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0]  <= 12'd2048;
            r_center[1]  <= 12'd2048;
            r_dead_band  <= 12'd100;
            r_mid_low    <= 12'd1024;
            r_mid_high   <= 12'd3072;
            r_move_range <= 12'd200;
            r_rest_band  <= 12'd300;
            r_confirm    <= 8'd5;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HOME_X:        r_center[0]  <= i_cfg_data;
                CFG_HOME_Y:        r_center[1]  <= i_cfg_data;
                CFG_DEAD_BAND:     r_dead_band  <= i_cfg_data;
                CFG_MID_LOW:       r_mid_low    <= i_cfg_data;
                CFG_MID_HIGH:      r_mid_high   <= i_cfg_data;
                CFG_MOVE_RANGE:    r_move_range <= i_cfg_data;
                CFG_REST_BAND:     r_rest_band  <= i_cfg_data;
                CFG_CONFIRM_COUNT: r_confirm    <= i_cfg_data[CONFIRM_W-1:0];
                default: ;
            endcase
        end
    end

    // window and streak
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < 2; l++) begin
                r_wmin[l] <= '0;
                r_wmax[l] <= '0;
            end
            r_win_pos <= '0;
            r_streak  <= '0;
        end else begin
            if (i_cmd.load) begin
                for (int l = 0; l < 2; l++) begin
                    if (r_win_pos == '0) begin
                        r_wmin[l] <= w_in[l];
                        r_wmax[l] <= w_in[l];
                    end else begin
                        if (w_in[l] < r_wmin[l]) r_wmin[l] <= w_in[l];
                        if (w_in[l] > r_wmax[l]) r_wmax[l] <= w_in[l];
                    end
                end
                if (r_win_pos == WIN_POS_W'(WIN_LEN - 1)) begin
                    r_win_pos <= '0;
                end else begin
                    r_win_pos <= r_win_pos + 1'b1;
                end
            end
            if (i_cmd.eval) begin
                r_streak <= n_streak;
            end
        end
    end

    // shaping lanes and output payload
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.load) begin
                r_raw[l] <= w_in[l];
            end
            if (i_cmd.eval) begin
                r_c[l]    <= w_ceff[l];
                r_d[l]    <= w_d[l];
                r_neg[l]  <= w_neg[l];
                r_zero[l] <= w_d[l] < r_dead_band;
                r_sat[l]  <= w_d[l] >= w_ceff[l];
            end
            if (i_cmd.sq_d) begin
                r_dd[l] <= w_prod[l];
            end
            if (i_cmd.sq_c) begin
                r_cc[l] <= w_prod[l];
            end
            if (i_cmd.num) begin
                r_rem[l] <= w_num[l][NUM_W-2:MAG_W];
                r_lo[l]  <= w_num[l][MAG_W-1:0];
                r_q[l]   <= '0;
            end
            if (i_cmd.div_step) begin
                r_rem[l] <= w_ge[l] ? w_diff[l][SQ_W-1:0] : w_trial[l][SQ_W-1:0];
                r_lo[l]  <= {r_lo[l][MAG_W-2:0], 1'b0};
                r_q[l]   <= {r_q[l][MAG_W-2:0], w_ge[l]};
            end
        end
        if (i_cmd.eval) begin
            r_conn <= n_conn;
        end
        if (i_cmd.out_load) begin
            o_x_out     <= w_res[0];
            o_y_out     <= w_res[1];
            o_connected <= r_conn;
        end
    end

endmodule

// File: src/joystick_axis_conditioner_top.sv
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_top
// dead zone, normalize and square curve per axis, plus a connected flag
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready | i_x_sample, i_y_sample
//  output   | o_out_valid/i_out_ready | o_x_out, o_y_out, o_connected
//  config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
//  one transaction in gives one out; the steps from accept to result valid are:
//  evaluate, two squaring steps, numerator, 15 divider steps and the load
//  the next transaction is taken in the cycle after the output register
//  loads, so an item is not taken in before the last one is through
//  a stalled output holds its result; the sequencer waits before the load
//  reset is synchronous, active low; config returns to its documented values
//
// ----------------------------------------------------------------------------
module joystick_axis_conditioner_top
    import jac_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input transactions
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [SAMPLE_W-1:0]         i_x_sample,
    input  logic [SAMPLE_W-1:0]         i_y_sample,
    // result transactions
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_x_out,
    output logic signed [OUT_W-1:0]     o_y_out,
    output logic                        o_connected,
    // register writes
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [SAMPLE_W-1:0]         i_cfg_data
);

    // command bundle from the sequencer to the datapath
    t_jac_cmd cmd;

    // sequencer: owns handshakes, step counter and the result valid flag
    jac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // datapath: registers, window, connect check, two shaping lanes
    jac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_x_sample  (i_x_sample),
        .i_y_sample  (i_y_sample),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_connected (o_connected)
    );

endmodule
